### rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the base64url
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // widths
    localparam int unsigned SymW   = 8;
    localparam int unsigned SextW  = 6;
    localparam int unsigned ByteW  = 8;

    // queue between classifier and decode engine
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    // special characters
    localparam logic [SymW-1:0] PadChar   = 8'h3D;
    localparam logic [SymW-1:0] DashChar  = 8'h2D;
    localparam logic [SymW-1:0] UnderChar = 8'h5F;

    // pad count limit
    localparam logic [1:0] PadMax = 2'd2;

    // character class
    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_PAD,
        CLS_BAD
    } t_sym_cls;

    // classified item handed from front to back
    typedef struct packed {
        t_sym_cls               cls;
        logic [SextW-1:0]       sextet;
        logic                   last;
    } t_cls_item;

    // queue status
    typedef struct packed {
        logic                   empty;
        logic                   full;
        logic [QCntW-1:0]       count;
    } t_q_stat;

    // map one character to its class and six-bit value
    function automatic t_cls_item classify(input logic [SymW-1:0] ch, input logic last);
        t_cls_item        item;
        logic [SymW-1:0]  diff;
        item.cls    = CLS_BAD;
        item.sextet = '0;
        item.last   = last;
        diff        = '0;
        priority if (ch >= 8'h41 && ch <= 8'h5A) begin
            diff        = ch - 8'h41;
            item.cls    = CLS_DATA;
            item.sextet = diff[SextW-1:0];
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            diff        = ch - 8'h61 + 8'd26;
            item.cls    = CLS_DATA;
            item.sextet = diff[SextW-1:0];
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            diff        = ch - 8'h30 + 8'd52;
            item.cls    = CLS_DATA;
            item.sextet = diff[SextW-1:0];
        end else if (ch == DashChar) begin
            item.cls    = CLS_DATA;
            item.sextet = 6'd62;
        end else if (ch == UnderChar) begin
            item.cls    = CLS_DATA;
            item.sextet = 6'd63;
        end else if (ch == PadChar) begin
            item.cls    = CLS_PAD;
        end else begin
            item.cls    = CLS_BAD;
        end
        return item;
    endfunction

endpackage

### rtl/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Input stage: accepts characters, classifies them and holds the classified
// item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [b64d_pkg::SymW-1:0]     i_s_tdata,     // [7:0] symbol
    input  logic                          i_s_tlast,
    output logic                          o_push,
    output b64d_pkg::t_cls_item           o_item,
    input  logic                          i_q_full
);

    logic                 r_valid;
    logic                 n_valid;
    b64d_pkg::t_cls_item  r_item;
    logic                 w_accept;

    // stage is free when empty or draining into the queue this cycle
    assign o_push     = r_valid && !i_q_full;
    assign o_s_tready = !r_valid || !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_item     = r_item;

    // stage occupancy
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // classified payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= b64d_pkg::classify(i_s_tdata, i_s_tlast);
        end
    end

endmodule

### rtl/b64d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Small first-in first-out queue of classified items between the front stage
// and the decode engine.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b64d_pkg::t_cls_item   i_item,
    input  logic                  i_pop,
    output b64d_pkg::t_cls_item   o_item,
    output b64d_pkg::t_q_stat     o_stat
);

    b64d_pkg::t_cls_item                r_mem [b64d_pkg::QDepth];
    logic [b64d_pkg::QAw-1:0]           r_wr_ptr;
    logic [b64d_pkg::QAw-1:0]           r_rd_ptr;
    logic [b64d_pkg::QCntW-1:0]         r_count;
    logic [b64d_pkg::QAw-1:0]           n_wr_ptr;
    logic [b64d_pkg::QAw-1:0]           n_rd_ptr;
    logic [b64d_pkg::QCntW-1:0]         n_count;

    // status
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == b64d_pkg::QCntW'(b64d_pkg::QDepth));
    assign o_stat.count = r_count;

    // head of queue
    assign o_item = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Decode engine: takes classified items from the queue, assembles bytes from
// six-bit groups, tracks padding and errors, and drives the output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  b64d_pkg::t_cls_item            i_item,
    input  logic                           i_q_empty,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [b64d_pkg::ByteW-1:0]     o_m_tdata,   // [7:0] data_byte
    output logic                           o_m_tlast,
    output logic [1:0]                     o_m_tuser    // [0] byte_present, [1] bad_input
);

    // decode state
    logic [1:0]                    r_phase;
    logic [b64d_pkg::SextW-1:0]    r_carry;
    logic [1:0]                    r_pad;
    logic                          r_err;
    logic [1:0]                    n_phase;
    logic [b64d_pkg::SextW-1:0]    n_carry;
    logic [1:0]                    n_pad;
    logic                          n_err;

    // output register
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [b64d_pkg::ByteW-1:0]    r_data;
    logic                          r_present;
    logic                          r_final;
    logic                          r_bad;

    // step results
    logic                          w_have;
    logic [b64d_pkg::ByteW-1:0]    w_byte;
    logic                          w_err;
    logic [1:0]                    w_phase;
    logic [b64d_pkg::SextW-1:0]    w_carry;
    logic [1:0]                    w_pad;
    logic                          w_bad;
    logic                          w_emit;
    logic [b64d_pkg::ByteW-1:0]    w_out_data;
    logic                          w_out_present;

    // take the next item whenever the output register can load
    assign o_pop = !i_q_empty && (!r_out_valid || i_m_tready);

    // one character step
    always_comb begin
        w_have  = 1'b0;
        w_byte  = '0;
        w_err   = r_err;
        w_phase = r_phase;
        w_carry = r_carry;
        w_pad   = r_pad;
        if (!r_err) begin
            unique case (i_item.cls)
                b64d_pkg::CLS_DATA: begin
                    if (r_pad != 2'd0) begin
                        w_err = 1'b1;
                    end else begin
                        w_phase = r_phase + 2'd1;
                        unique case (r_phase)
                            2'd0: begin
                                w_carry = i_item.sextet;
                            end
                            2'd1: begin
                                w_byte  = {r_carry, i_item.sextet[5:4]};
                                w_carry = {2'b00, i_item.sextet[3:0]};
                                w_have  = 1'b1;
                            end
                            2'd2: begin
                                w_byte  = {r_carry[3:0], i_item.sextet[5:2]};
                                w_carry = {4'b0000, i_item.sextet[1:0]};
                                w_have  = 1'b1;
                            end
                            default: begin
                                w_byte  = {r_carry[1:0], i_item.sextet};
                                w_carry = '0;
                                w_have  = 1'b1;
                            end
                        endcase
                    end
                end
                b64d_pkg::CLS_PAD: begin
                    if (r_pad >= b64d_pkg::PadMax) begin
                        w_err = 1'b1;
                    end else begin
                        w_pad = r_pad + 2'd1;
                    end
                end
                default: begin
                    w_err = 1'b1;
                end
            endcase
        end

        // end-of-text check: padded length must be a multiple of four, else not 1 mod 4
        w_bad = 1'b1;
        if (!w_err) begin
            unique case (w_pad)
                2'd0:    w_bad = (w_phase == 2'd1);
                2'd1:    w_bad = (w_phase != 2'd3);
                default: w_bad = (w_phase != 2'd2);
            endcase
        end

        // result for this item
        if (i_item.last) begin
            w_emit        = 1'b1;
            w_out_present = w_have && !w_bad;
            w_out_data    = w_out_present ? w_byte : '0;
        end else begin
            w_emit        = w_have;
            w_out_present = 1'b1;
            w_out_data    = w_byte;
        end
    end

    // state update, cleared after the final character
    always_comb begin
        n_phase = r_phase;
        n_carry = r_carry;
        n_pad   = r_pad;
        n_err   = r_err;
        if (o_pop) begin
            if (i_item.last) begin
                n_phase = '0;
                n_carry = '0;
                n_pad   = '0;
                n_err   = 1'b0;
            end else begin
                n_phase = w_phase;
                n_carry = w_carry;
                n_pad   = w_pad;
                n_err   = w_err;
            end
        end
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = w_emit;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_carry     <= '0;
            r_pad       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_carry     <= n_carry;
            r_pad       <= n_pad;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_data    <= w_out_data;
            r_present <= w_out_present;
            r_final   <= i_item.last;
            r_bad     <= i_item.last && w_bad;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_final;
    assign o_m_tuser  = {r_bad, r_present};

endmodule

### rtl/base64url_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_stream_decoder_core
// Decodes a base64url text arriving one character per item into bytes, with
// a validity verdict on the result of the final character.
// ----------------------------------------------------------------------------
//
//  port group | dir | tdata        | tlast        | tuser
//  -----------+-----+--------------+--------------+--------------------------
//  s_axis     | in  | symbol       | end_of_text  | -
//  m_axis     | out | data_byte    | final_res    | byte_present, bad_input
//
//  One item per clock sustained while m_axis takes results; an accepted item
//  passes the front register and the queue before its result is loaded
//  into the output register. The back engine's decode step sets the rate.
//  Reset is synchronous, active low, and clears the queue, the decode state
//  and the output register; no clearing pass is needed.
//  A stall on m_axis fills the four-entry queue before s_axis is held off.
//
module base64url_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] symbol
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // [7:0] data_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser      // [0] byte_present, [1] bad_input
);

    logic                  w_push;
    logic                  w_pop;
    b64d_pkg::t_cls_item   w_front_item;
    b64d_pkg::t_cls_item   w_head_item;
    b64d_pkg::t_q_stat     w_q_stat;

    // accept and classify
    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .o_push     (w_push),
        .o_item     (w_front_item),
        .i_q_full   (w_q_stat.full)
    );

    // decoupling queue
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_q_stat)
    );

    // decode engine and output register
    b64d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_head_item),
        .i_q_empty  (w_q_stat.empty),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

    // a result that is not final always carries a byte
    a_nonfinal_has_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0] && !m_axis_tuser[1])
        else $error("non-final result without a byte");

    // a rejected text gives no byte on its final result
    a_bad_no_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && (m_axis_tdata == 8'd0))
        else $error("bad final result carries a byte");

    // queue occupancy stays within its depth and status agrees with it
    a_queue_bounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.count <= b64d_pkg::QCntW'(b64d_pkg::QDepth))
            && !(w_q_stat.full && w_q_stat.empty))
        else $error("queue occupancy out of range");

    // no pop from an empty queue, no push into a full one
    a_queue_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_stat.empty) && !(w_push && w_q_stat.full))
        else $error("queue overflow or underflow");

endmodule
